// ===== design/golden_section_search_sequencer_assert.svh =====
// Assertion macros shared by the search sequencer modules.
// GSS_ASSERT is disabled while reset is high; GSS_ASSERT_ALWAYS is checked on every edge.
`ifndef GOLDEN_SECTION_SEARCH_SEQUENCER_ASSERT_SVH
`define GOLDEN_SECTION_SEARCH_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define GSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("golden section search check failed");
`define GSS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("golden section search check failed");
`else
`define GSS_ASSERT(label, clk, rst, prop)
`define GSS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/gss_pkg.sv =====
`timescale 1ns / 1ps

package gss_pkg;

   localparam int POINT_W = 24;
   localparam int VALUE_W = 32;
   localparam int TOL_W   = 16;
   localparam int FRAC_W  = 16;

   // golden constants, Q0.16: C = (3 - sqrt 5) / 2, R = 1 - C
   localparam logic [FRAC_W-1:0] GOLD_C = 16'd25033;
   localparam logic [FRAC_W-1:0] GOLD_R = 16'd40503;

   localparam logic [POINT_W-1:0] LOWER_RESET = 24'd0;
   localparam logic [POINT_W-1:0] START_RESET = 24'd5242880;
   localparam logic [POINT_W-1:0] UPPER_RESET = 24'd16711680;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd655;

   typedef logic [POINT_W-1:0]        point_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [TOL_W-1:0]          tol_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_VALUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_PROBE   = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_LOWER = 2'd0,
      CSR_START = 2'd1,
      CSR_UPPER = 2'd2,
      CSR_TOL   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_FIRST_F1 = 4'b0010,
      PH_WANT_F1  = 4'b0100,
      PH_WANT_F2  = 4'b1000
   } phase_type;

   typedef struct packed {
      point_type lower;
      point_type start;
      point_type upper;
      tol_type   tol;
   } cfg_type;

   typedef struct packed {
      kind_type  kind;
      point_type point;
      value_type best_value;
   } result_type;

   // clamp a signed intermediate into the unsigned point range
   function automatic point_type sat_point(input logic signed [POINT_W+1:0] v);
      point_type r;
      if (v < 0) begin
         r = '0;
      end else if (v[POINT_W+1:POINT_W] != 2'b00) begin
         r = '1;
      end else begin
         r = v[POINT_W-1:0];
      end
      return r;
   endfunction

   // floor(d * C / 2^16) for a signed point difference
   function automatic logic signed [POINT_W:0] scale_c(input logic signed [POINT_W:0] d);
      logic signed [POINT_W+FRAC_W:0] p;
      p = d * $signed({1'b0, GOLD_C});
      return p[POINT_W+FRAC_W:FRAC_W];
   endfunction

   // floor(R * near) + floor(C * far), saturated
   function automatic point_type golden_mix(input point_type near, input point_type far);
      logic [POINT_W+FRAC_W-1:0] pn;
      logic [POINT_W+FRAC_W-1:0] pf;
      logic [POINT_W:0]          s;
      pn = near * GOLD_R;
      pf = far * GOLD_C;
      s  = {1'b0, pn[POINT_W+FRAC_W-1:FRAC_W]} + {1'b0, pf[POINT_W+FRAC_W-1:FRAC_W]};
      return s[POINT_W] ? '1 : s[POINT_W-1:0];
   endfunction

endpackage

// ===== design/golden_section_search_sequencer.sv =====
`timescale 1ns / 1ps
// Path: an item's result passes through the input register, then the result register,
//   before it is on the outputs.
// Throughput: one item per cycle when the result side keeps up; the core state update
//   is the only loop.
// Reset (synchronous, active high): both stages empty, search idle, registers at defaults.
`include "golden_section_search_sequencer_assert.svh"

module golden_section_search_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // [31:0] probe_value
   input  logic                        req_tuser,   // [0] cmd
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [55:0]                 rsp_tdata,   // [23:0] point, [55:24] best_value
   output logic [1:0]                  rsp_tuser,   // [1:0] kind
   // register writes
   input  logic                        csr_we,
   input  gss_pkg::csr_index_type      csr_index,
   input  logic [gss_pkg::POINT_W-1:0] csr_wdata
);
   import gss_pkg::*;

   // configuration registers
   cfg_type    cfg_ff;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   cmd_type    s1_cmd_ff;
   value_type  s1_value_ff;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type core_result;

   logic       req_xfer;
   logic       out_free;
   logic       commit;

   // the result register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lower: LOWER_RESET, start: START_RESET, upper: UPPER_RESET,
                     tol: TOL_RESET};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER: cfg_ff.lower <= csr_wdata;
            CSR_START: cfg_ff.start <= csr_wdata;
            CSR_UPPER: cfg_ff.upper <= csr_wdata;
            CSR_TOL:   cfg_ff.tol   <= csr_wdata[TOL_W-1:0];
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff   <= cmd_type'(req_tuser);
         s1_value_ff <= req_tdata;
      end
      if (commit) begin
         rsp_result_ff <= core_result;
      end
   end

   gss_core u_core (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .cmd         (s1_cmd_ff),
      .probe_value (s1_value_ff),
      .cfg         (cfg_ff),
      .result      (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.kind;
   assign rsp_tdata  = {rsp_result_ff.best_value, rsp_result_ff.point};

   `GSS_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
   `GSS_ASSERT(a_full_and_stalled_blocks, clock, reset,
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
   `GSS_ASSERT(a_probe_value_zero, clock, reset,
      (rsp_valid_ff && rsp_result_ff.kind != KIND_DONE) |-> (rsp_result_ff.best_value == '0))
   `GSS_ASSERT(a_ignored_point_zero, clock, reset,
      (rsp_valid_ff && rsp_result_ff.kind == KIND_IGNORED) |-> (rsp_result_ff.point == '0))

endmodule

// ===== design/gss_core.sv =====
`timescale 1ns / 1ps
`include "golden_section_search_sequencer_assert.svh"

module gss_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 commit,
   input  gss_pkg::cmd_type     cmd,
   input  gss_pkg::value_type   probe_value,
   input  gss_pkg::cfg_type     cfg,
   output gss_pkg::result_type  result
);
   import gss_pkg::*;

   point_type x0_ff, x1_ff, x2_ff, x3_ff;
   point_type x0_in, x1_in, x2_in, x3_in;
   value_type f1_ff, f2_ff, f1_in, f2_in;
   phase_type phase_ff, phase_in;

   // start: interior points on the wider side of the start point
   logic signed [POINT_W:0] right, left, abs_right, abs_left;
   point_type               start_x1, start_x2;

   // narrowing: both candidate new points come from the current bracket
   point_type               mix_up, mix_down;
   logic [POINT_W:0]        pair_sum;
   logic [POINT_W+TOL_W:0]  bound_prod;
   logic [POINT_W:0]        bound;
   logic signed [POINT_W:0] span;
   logic [POINT_W:0]        width;
   logic                    stop;
   value_type               fl, fh;

   assign right     = $signed({1'b0, cfg.upper}) - $signed({1'b0, cfg.start});
   assign left      = $signed({1'b0, cfg.start}) - $signed({1'b0, cfg.lower});
   assign abs_right = (right < 0) ? -right : right;
   assign abs_left  = (left < 0) ? -left : left;

   always_comb begin
      logic signed [POINT_W:0] sr;
      logic signed [POINT_W:0] sl;
      sr = scale_c(right);
      sl = scale_c(left);
      start_x2 = sat_point($signed({2'b00, cfg.start}) + $signed({sr[POINT_W], sr}));
      start_x1 = sat_point($signed({2'b00, cfg.start}) - $signed({sl[POINT_W], sl}));
   end

   assign mix_up     = golden_mix(x2_ff, x3_ff);
   assign mix_down   = golden_mix(x1_ff, x0_ff);
   assign pair_sum   = {1'b0, x1_ff} + {1'b0, x2_ff};
   assign bound_prod = cfg.tol * pair_sum;
   assign bound      = bound_prod[POINT_W+TOL_W:TOL_W];
   assign span       = $signed({1'b0, x3_ff}) - $signed({1'b0, x0_ff});
   assign width      = (span < 0) ? -span : span;
   assign stop       = (width <= bound);

   assign fl = (phase_ff == PH_WANT_F1) ? probe_value : f1_ff;
   assign fh = (phase_ff == PH_WANT_F2) ? probe_value : f2_ff;

   always_comb begin
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      x2_in    = x2_ff;
      x3_in    = x3_ff;
      f1_in    = f1_ff;
      f2_in    = f2_ff;
      phase_in = phase_ff;
      result   = '{kind: KIND_IGNORED, point: '0, best_value: '0};
      if (cmd == CMD_START) begin
         // a start aborts whatever search is running
         x0_in    = cfg.lower;
         x3_in    = cfg.upper;
         f1_in    = '0;
         f2_in    = '0;
         phase_in = PH_FIRST_F1;
         if (abs_right > abs_left) begin
            x1_in = cfg.start;
            x2_in = start_x2;
         end else begin
            x1_in = start_x1;
            x2_in = cfg.start;
         end
         result = '{kind: KIND_PROBE, point: x1_in, best_value: '0};
      end else begin
         unique case (phase_ff)
            PH_FIRST_F1: begin
               f1_in    = probe_value;
               phase_in = PH_WANT_F2;
               result   = '{kind: KIND_PROBE, point: x2_ff, best_value: '0};
            end
            PH_WANT_F1, PH_WANT_F2: begin
               f1_in = fl;
               f2_in = fh;
               if (stop) begin
                  phase_in = PH_IDLE;
                  if (fl < fh) begin
                     result = '{kind: KIND_DONE, point: x1_ff, best_value: fl};
                  end else begin
                     result = '{kind: KIND_DONE, point: x2_ff, best_value: fh};
                  end
               end else if (fh < fl) begin
                  // minimum lies right of x1: drop [x0, x1)
                  x0_in    = x1_ff;
                  x1_in    = x2_ff;
                  x2_in    = mix_up;
                  f1_in    = fh;
                  phase_in = PH_WANT_F2;
                  result   = '{kind: KIND_PROBE, point: mix_up, best_value: '0};
               end else begin
                  x3_in    = x2_ff;
                  x2_in    = x1_ff;
                  x1_in    = mix_down;
                  f2_in    = fl;
                  phase_in = PH_WANT_F1;
                  result   = '{kind: KIND_PROBE, point: mix_down, best_value: '0};
               end
            end
            default: begin
               // value while idle: state untouched
               result = '{kind: KIND_IGNORED, point: '0, best_value: '0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff    <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         x3_ff    <= '0;
         f1_ff    <= '0;
         f2_ff    <= '0;
         phase_ff <= PH_IDLE;
      end else if (commit) begin
         x0_ff    <= x0_in;
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         x3_ff    <= x3_in;
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         phase_ff <= phase_in;
      end
   end

   `GSS_ASSERT(a_done_goes_idle, clock, reset,
      (commit && result.kind == KIND_DONE) |=> (phase_ff == PH_IDLE))
   `GSS_ASSERT(a_start_waits_f1, clock, reset,
      (commit && cmd == CMD_START) |=> (phase_ff == PH_FIRST_F1))
   `GSS_ASSERT(a_idle_value_ignored, clock, reset,
      (commit && cmd == CMD_VALUE && phase_ff == PH_IDLE) |-> (result.kind == KIND_IGNORED))

endmodule
